// File: hw/rtl/plm_pkg.sv
// Shared types and constants for the positional list with running maximum.
// Used by the channel interfaces, the storage cell and the top level.
// No dependencies.
package plm_pkg;

  localparam int WORD_W    = 32;
  localparam int POS_W     = 8;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int OUT_CNT_W = 5;

  localparam logic [WORD_W-1:0] EMPTY_MAX = {WORD_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SWAP   = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Action broadcast to every cell of the ring.
  typedef enum logic [2:0] {
    ACT_HOLD   = 3'd0,
    ACT_ROTATE = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_SWAP   = 3'd4
  } action_t;

  typedef struct packed {
    action_t           act;
    logic [POS_W-1:0]  idx_a;
    logic [POS_W-1:0]  idx_b;
    logic [WORD_W-1:0] val_a;
    logic [WORD_W-1:0] val_b;
  } cell_cmd_t;

endpackage

// File: hw/rtl/plm_in_if.sv
// Request channel of the positional list: valid/ready handshake and payload.
// Depends on plm_pkg for field widths.
interface plm_in_if;
  import plm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic [POS_W-1:0]         second_position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output op, output position, output second_position,
                  output value, input ready);
  modport sink   (input valid, input op, input position, input second_position,
                  input value, output ready);
endinterface

// File: hw/rtl/plm_out_if.sv
// Result channel of the positional list: valid/ready handshake and payload.
// Depends on plm_pkg for field widths.
interface plm_out_if;
  import plm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] removed_value;
  logic [OUT_CNT_W-1:0]     entry_count;
  logic signed [WORD_W-1:0] largest_value;
  logic [OUT_CNT_W-1:0]     largest_position;

  modport source (output valid, output status, output removed_value, output entry_count,
                  output largest_value, output largest_position, input ready);
  modport sink   (input valid, input status, input removed_value, input entry_count,
                  input largest_value, input largest_position, output ready);
endinterface

// File: hw/rtl/plm_cell.sv
// One storage cell of the list ring: holds a single entry and updates it
// from its neighbours or the broadcast command. Depends on plm_pkg.
module plm_cell (
  input  logic                      clk,
  input  plm_pkg::cell_cmd_t        cmd,
  input  logic [plm_pkg::POS_W-1:0] cell_idx,
  input  logic [plm_pkg::WORD_W-1:0] left_entry,
  input  logic [plm_pkg::WORD_W-1:0] right_entry,
  output logic [plm_pkg::WORD_W-1:0] entry
);
  import plm_pkg::*;

  logic [WORD_W-1:0] entry_r;
  logic [WORD_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.act)
      ACT_HOLD: begin
        entry_nxt = entry_r;
      end
      ACT_ROTATE: begin
        entry_nxt = right_entry;
      end
      ACT_INSERT: begin
        if (cell_idx > cmd.idx_a) begin
          entry_nxt = left_entry;
        end else if (cell_idx == cmd.idx_a) begin
          entry_nxt = cmd.val_a;
        end
      end
      ACT_REMOVE: begin
        if (cell_idx >= cmd.idx_a) begin
          entry_nxt = right_entry;
        end
      end
      ACT_SWAP: begin
        if (cell_idx == cmd.idx_a) begin
          entry_nxt = cmd.val_b;
        end else if (cell_idx == cmd.idx_b) begin
          entry_nxt = cmd.val_a;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: hw/rtl/positional_list_with_max_top.sv
// Top level of the positional list with running maximum.
// Depends on plm_pkg, plm_in_if, plm_out_if and plm_cell.
module positional_list_with_max_top #(
  parameter int CAPACITY = 16
) (
  input logic      clk,
  input logic      rst_n,
  plm_in_if.sink   in_chan,
  plm_out_if.source out_chan
);
  // Usage
  // -----
  // Each transaction on in_chan carries one operation (insert, remove or swap) on a
  // list of up to CAPACITY signed words with 1-based positions. Exactly one
  // transaction on out_chan answers it, giving the status, the removed value, the
  // entry count and the greatest entry with its first position.
  // The entries live in a ring of identical cells. Insert and remove shift every
  // affected cell towards its neighbour in one broadcast step. Reading entries (the
  // value to remove, the two values to swap, and the maximum) is done by rotating
  // the whole ring once past the head cell, one entry per cycle, which brings every
  // entry back to its own cell after CAPACITY steps.
  // Each operation runs through the sequencer states in order: an insert through edit,
  // scan and finish, a valid remove or swap first through gather (one extra ring pass
  // to fetch the values), and a rejected or unknown operation through scan and finish
  // alone. The input is ready again in the cycle the result appears.
  // The result sits in an output register, so a new transaction is accepted while
  // an earlier result still waits; a stalled receiver only holds the block once
  // a second result is ready to be written into that register.
  // Synchronous reset empties the list and drops any pending result; the entry
  // storage itself is not cleared, as only held entries are ever read.

  import plm_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_GATHER = 5'b00010,
    S_EDIT   = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  // Control state.
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Operation held for the duration of its passes.
  op_t               op_r, op_nxt;
  status_t           status_r, status_nxt;
  logic [IDX_W-1:0]  pa_r, pa_nxt;
  logic [IDX_W-1:0]  pb_r, pb_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [WORD_W-1:0] grab_a_r, grab_a_nxt;
  logic [WORD_W-1:0] grab_b_r, grab_b_nxt;
  logic [WORD_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]  bpos_r, bpos_nxt;

  // Result register.
  status_t              out_status_r, out_status_nxt;
  logic [WORD_W-1:0]    out_removed_r, out_removed_nxt;
  logic [OUT_CNT_W-1:0] out_count_r, out_count_nxt;
  logic [WORD_W-1:0]    out_largest_r, out_largest_nxt;
  logic [OUT_CNT_W-1:0] out_lpos_r, out_lpos_nxt;

  logic              in_accept;
  logic              last_step;
  logic              out_free;
  logic [WORD_W-1:0] head;
  logic [CMP_W-1:0]  p1_w, p2_w, cnt_w;
  logic              p1_in_list, p2_in_list, p1_insertable, list_full;
  status_t           req_status;
  cell_cmd_t         cell_cmd;
  logic [WORD_W-1:0] entries [CAPACITY];

  // ---------------------------------------------------------------------------
  // Ring of cells. Cell 0 is the head; rotation moves every entry one cell
  // towards the head and the head entry round to the tail.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    plm_cell u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .cell_idx    (POS_W'(g)),
      .left_entry  (entries[(g + CAPACITY - 1) % CAPACITY]),
      .right_entry (entries[(g + 1) % CAPACITY]),
      .entry       (entries[g])
    );
  end

  assign head = entries[0];

  // ---------------------------------------------------------------------------
  // Request checks against the current count.
  // ---------------------------------------------------------------------------
  assign p1_w  = CMP_W'(in_chan.position);
  assign p2_w  = CMP_W'(in_chan.second_position);
  assign cnt_w = CMP_W'(count_r);

  assign p1_in_list    = (in_chan.position != '0) && (p1_w <= cnt_w);
  assign p2_in_list    = (in_chan.second_position != '0) && (p2_w <= cnt_w);
  assign p1_insertable = (in_chan.position != '0) && (p1_w <= cnt_w + CMP_W'(1));
  assign list_full     = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    req_status = ST_DONE;
    unique case (in_chan.op)
      OP_INSERT: begin
        if (list_full) begin
          req_status = ST_FULL;
        end else if (!p1_insertable) begin
          req_status = ST_RANGE;
        end
      end
      OP_REMOVE: begin
        if (!p1_in_list) begin
          req_status = ST_RANGE;
        end
      end
      OP_SWAP: begin
        if (!p1_in_list || !p2_in_list) begin
          req_status = ST_RANGE;
        end
      end
      default: begin
        req_status = ST_DONE;
      end
    endcase
  end

  assign in_accept = in_chan.valid && in_chan.ready;
  assign last_step = (step_r == IDX_W'(CAPACITY - 1));
  assign out_free  = !out_valid_r || out_chan.ready;

  // ---------------------------------------------------------------------------
  // Command broadcast to the cells.
  // ---------------------------------------------------------------------------
  always_comb begin
    cell_cmd.act   = ACT_HOLD;
    cell_cmd.idx_a = POS_W'(pa_r);
    cell_cmd.idx_b = POS_W'(pb_r);
    cell_cmd.val_a = (op_r == OP_INSERT) ? val_r : grab_a_r;
    cell_cmd.val_b = grab_b_r;
    unique case (state_r)
      S_GATHER, S_SCAN: begin
        cell_cmd.act = ACT_ROTATE;
      end
      S_EDIT: begin
        unique case (op_r)
          OP_INSERT: cell_cmd.act = ACT_INSERT;
          OP_REMOVE: cell_cmd.act = ACT_REMOVE;
          OP_SWAP:   cell_cmd.act = ACT_SWAP;
          default:   cell_cmd.act = ACT_HOLD;
        endcase
      end
      default: begin
        cell_cmd.act = ACT_HOLD;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and head-cell tracking.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    op_nxt          = op_r;
    status_nxt      = status_r;
    pa_nxt          = pa_r;
    pb_nxt          = pb_r;
    val_nxt         = val_r;
    grab_a_nxt      = grab_a_r;
    grab_b_nxt      = grab_b_r;
    best_nxt        = best_r;
    bpos_nxt        = bpos_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_count_nxt   = out_count_r;
    out_largest_nxt = out_largest_r;
    out_lpos_nxt    = out_lpos_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt     = op_t'(in_chan.op);
          status_nxt = req_status;
          pa_nxt     = IDX_W'(in_chan.position - POS_W'(1));
          pb_nxt     = IDX_W'(in_chan.second_position - POS_W'(1));
          val_nxt    = in_chan.value;
          grab_a_nxt = '0;
          grab_b_nxt = '0;
          best_nxt   = '0;
          bpos_nxt   = '0;
          step_nxt   = '0;
          if (req_status != ST_DONE) begin
            state_nxt = S_SCAN;
          end else begin
            unique case (in_chan.op)
              OP_INSERT:         state_nxt = S_EDIT;
              OP_REMOVE, OP_SWAP: state_nxt = S_GATHER;
              default:           state_nxt = S_SCAN;
            endcase
          end
        end
      end
      S_GATHER: begin
        // The head cell shows entry number step_r of the list.
        if (step_r == pa_r) begin
          grab_a_nxt = head;
        end
        if (step_r == pb_r) begin
          grab_b_nxt = head;
        end
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = S_EDIT;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      S_EDIT: begin
        if (op_r == OP_INSERT) begin
          count_nxt = count_r + CNT_W'(1);
        end else if (op_r == OP_REMOVE) begin
          count_nxt = count_r - CNT_W'(1);
        end
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // Strictly greater keeps the first position on ties.
        if (CNT_W'(step_r) < count_r) begin
          if ((step_r == '0) || ($signed(head) > $signed(best_r))) begin
            best_nxt = head;
            bpos_nxt = CNT_W'(step_r) + CNT_W'(1);
          end
        end
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = S_FINISH;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = ((op_r == OP_REMOVE) && (status_r == ST_DONE)) ? grab_a_r : '0;
          out_count_nxt   = OUT_CNT_W'(count_r);
          out_largest_nxt = (count_r == '0) ? EMPTY_MAX : best_r;
          out_lpos_nxt    = OUT_CNT_W'(bpos_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    status_r      <= status_nxt;
    pa_r          <= pa_nxt;
    pb_r          <= pb_nxt;
    val_r         <= val_nxt;
    grab_a_r      <= grab_a_nxt;
    grab_b_r      <= grab_b_nxt;
    best_r        <= best_nxt;
    bpos_r        <= bpos_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_count_r   <= out_count_nxt;
    out_largest_r <= out_largest_nxt;
    out_lpos_r    <= out_lpos_nxt;
  end

  // ---------------------------------------------------------------------------
  // Channel outputs.
  // ---------------------------------------------------------------------------
  assign in_chan.ready             = rst_n && (state_r == S_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_status_r;
  assign out_chan.removed_value    = out_removed_r;
  assign out_chan.entry_count      = out_count_r;
  assign out_chan.largest_value    = out_largest_r;
  assign out_chan.largest_position = out_lpos_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_chan.ready)
    else $error("new transaction accepted while an operation is in flight");

  a_idle_step_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (step_r == '0))
    else $error("ring left rotated at the end of an operation");

  a_max_position : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |-> ((bpos_r <= count_r) && ((bpos_r == '0) == (count_r == '0))))
    else $error("position of the greatest entry inconsistent with the count");

endmodule

// File: tb/plm_tb_pkg.sv
// Checking support for the positional list testbench: a list tracker class
// that predicts each result and compares the results that the block returns.
// Depends on plm_pkg for the operation and status codes and the field widths.
package plm_tb_pkg;
  import plm_pkg::*;

  localparam int LIST_DEPTH = 16;

  localparam logic [OP_W-1:0]          OP_UNUSED = 2'd3;
  localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] removed_value;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic signed [WORD_W-1:0] largest_value;
    logic [OUT_CNT_W-1:0]     largest_position;
  } list_result_t;

  class list_tracker;
    logic signed [WORD_W-1:0] entries [LIST_DEPTH];
    int                       held;
    list_result_t             pending_results [$];
    int                       error_count;
    int                       results_checked;
    int                       done_seen;
    int                       range_seen;
    int                       full_seen;

    function new();
      foreach (entries[i]) entries[i] = '0;
      held            = 0;
      error_count     = 0;
      results_checked = 0;
      done_seen       = 0;
      range_seen      = 0;
      full_seen       = 0;
    endfunction

    // Applies one accepted request to the tracked list and queues the result.
    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos_a,
                               logic [POS_W-1:0] pos_b, logic signed [WORD_W-1:0] value);
      list_result_t             res;
      logic signed [WORD_W-1:0] swap_word;
      logic signed [WORD_W-1:0] best;
      int                       a;
      int                       b;
      int                       best_pos;
      a = pos_a;
      b = pos_b;
      res.status        = ST_DONE;
      res.removed_value = '0;
      case (op)
        OP_INSERT: begin
          // A full list is reported before the position is looked at.
          if (held >= LIST_DEPTH) res.status = ST_FULL;
          else if (a < 1 || a > held + 1) res.status = ST_RANGE;
          else begin
            for (int i = held; i >= a; i--) entries[i] = entries[i-1];
            entries[a-1] = value;
            held++;
          end
        end
        OP_REMOVE: begin
          if (a < 1 || a > held) res.status = ST_RANGE;
          else begin
            res.removed_value = entries[a-1];
            for (int i = a; i < held; i++) entries[i-1] = entries[i];
            held--;
          end
        end
        OP_SWAP: begin
          if (a < 1 || a > held || b < 1 || b > held) res.status = ST_RANGE;
          else begin
            swap_word    = entries[a-1];
            entries[a-1] = entries[b-1];
            entries[b-1] = swap_word;
          end
        end
        default: ;
      endcase

      // Strict comparison keeps the lowest position on a tie.
      res.largest_value    = EMPTY_MAX;
      res.largest_position = '0;
      if (held > 0) begin
        best     = entries[0];
        best_pos = 1;
        for (int i = 1; i < held; i++) begin
          if (entries[i] > best) begin
            best     = entries[i];
            best_pos = i + 1;
          end
        end
        res.largest_value    = best;
        res.largest_position = best_pos[OUT_CNT_W-1:0];
      end
      res.entry_count = held[OUT_CNT_W-1:0];

      case (res.status)
        ST_DONE:  done_seen++;
        ST_RANGE: range_seen++;
        default:  full_seen++;
      endcase
      pending_results.push_back(res);
    endfunction

    function void compare_field(string field_name, logic signed [40:0] want,
                                logic signed [40:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field_name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction arrived with no request outstanding");
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      compare_field("status", want.status, got.status);
      compare_field("removed_value", want.removed_value, got.removed_value);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("largest_value", want.largest_value, got.largest_value);
      compare_field("largest_position", want.largest_position, got.largest_position);
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench for the positional list with running maximum.
// Drives request transactions, checks every result against the list tracker.
// Depends on plm_pkg, plm_tb_pkg, the two channel interfaces and the block.
module tb_top;
  import plm_pkg::*;
  import plm_tb_pkg::*;

  // The run is cut short well beyond the slowest correct run: every request
  // meeting the longest sender gap and the longest receiver stall, plus the
  // long receiver hold-off and the drain pause.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int SEGMENT_LEN   = 40;
  localparam int QUIET_ITEMS   = 150;
  localparam int HOLD_OFF_LEN  = 200;

  logic clk;
  logic rst_n;

  plm_in_if  in_chan ();
  plm_out_if out_chan ();

  positional_list_with_max_top #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  list_tracker tracker;

  // Idling controls shared between the sender and the receiver. The sender
  // sets them per segment of the random part; the receiver only reads them,
  // apart from counting down a requested hold-off on its own.
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  rx_hold_cycles;
  bit  quiet_tail;
  int  requests_sent;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: if the run has not finished by the limit, something has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Receiver: ready changes on the falling edge. Random stall bursts, a long
  // hold-off when the sender asks for one, and no random stalls at all once
  // the quiet tail of the run has begun.
  initial begin
    int rx_stall_left;
    rx_stall_left  = 0;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_chan.ready = 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        out_chan.ready = 1'b0;
        rx_stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 99) < rx_idle_pct) begin
        out_chan.ready = 1'b0;
        rx_stall_left  = $urandom_range(0, 14);
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Result monitor: a transaction completes at a rising edge with valid and
  // ready both high, and is compared against the oldest prediction.
  initial begin
    list_result_t observed;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        observed.status           = status_t'(out_chan.status);
        observed.removed_value    = out_chan.removed_value;
        observed.entry_count      = out_chan.entry_count;
        observed.largest_value    = out_chan.largest_value;
        observed.largest_position = out_chan.largest_position;
        tracker.check_result(observed);
      end
    end
  end

  // Offers one request from a falling edge and holds it until accepted. The
  // task returns on the falling edge after acceptance, so that a following
  // request can be presented straight away with valid kept high.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos_a,
                              input logic [POS_W-1:0] pos_b,
                              input logic signed [WORD_W-1:0] value);
    in_chan.valid           = 1'b1;
    in_chan.op              = op;
    in_chan.position        = pos_a;
    in_chan.second_position = pos_b;
    in_chan.value           = value;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    tracker.note_request(op, pos_a, pos_b, value);
    requests_sent++;
    @(negedge clk);
  endtask

  // Values lean towards the extremes and a narrow band, so that ties for
  // the maximum turn up often.
  function automatic logic signed [WORD_W-1:0] pick_value();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return -32'sd1;
      3:       return '0;
      4, 5:    return $signed($urandom_range(0, 20)) - 32'sd10;
      default: return $urandom();
    endcase
  endfunction

  // Directed opening: empty-list errors, filling to capacity with the
  // extreme values and a tie for the maximum, an insert into a full list,
  // every kind of swap, the unused operation code and removals.
  task automatic run_directed();
    send_request(OP_REMOVE, 8'd1, 8'd0, '0);
    send_request(OP_SWAP, 8'd1, 8'd1, '0);
    send_request(OP_INSERT, 8'd0, 8'd0, 32'sd5);
    send_request(OP_INSERT, 8'd2, 8'd0, 32'sd5);
    send_request(OP_INSERT, 8'd1, 8'hFF, WORD_MIN);
    send_request(OP_INSERT, 8'd1, 8'd0, WORD_MAX);
    send_request(OP_INSERT, 8'd3, 8'd0, -32'sd1);
    send_request(OP_INSERT, 8'd2, 8'd0, WORD_MAX);
    for (int i = 0; i < LIST_DEPTH - 4; i++) begin
      send_request(OP_INSERT, 8'($urandom_range(1, tracker.held + 1)), 8'($urandom()),
                   pick_value());
    end
    // The list is full now, so a full status wins over the bad position.
    send_request(OP_INSERT, 8'd0, 8'd0, 32'sd1);
    send_request(OP_SWAP, 8'd1, 8'd16, '0);
    send_request(OP_SWAP, 8'd7, 8'd7, '0);
    send_request(OP_SWAP, 8'd0, 8'd3, '0);
    send_request(OP_UNUSED, 8'd4, 8'd9, 32'sd77);
    send_request(OP_REMOVE, 8'd17, 8'd0, '0);
    send_request(OP_REMOVE, 8'd16, 8'd0, '0);
    send_request(OP_REMOVE, 8'd1, 8'd0, '0);
  endtask

  // Random part. Most requests are well formed against the tracked entry
  // count so that the list sweeps between empty and full; the remainder are
  // deliberately out of range or entirely random noise.
  task automatic run_random(input int n_items);
    int               insert_bias;
    int               k;
    int               bad_lo;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    for (int n = 0; n < n_items; n++) begin
      if (n % SEGMENT_LEN == 0 && !quiet_tail) begin
        case ($urandom_range(0, 2))
          0:       insert_bias = 85;
          1:       insert_bias = 50;
          default: insert_bias = 20;
        endcase
        case ($urandom_range(0, 2))
          0:       tx_idle_pct = 0;
          1:       tx_idle_pct = 10;
          default: tx_idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_idle_pct = 0;
          1:       rx_idle_pct = 10;
          default: rx_idle_pct = 35;
        endcase
      end
      if (n == n_items - QUIET_ITEMS) begin
        quiet_tail  = 1'b1;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // Long receiver hold-off while requests keep coming, so the block
      // backs up and has to stall its input.
      if (n == 500) rx_hold_cycles = HOLD_OFF_LEN;

      // Sender pause until every outstanding result has been returned.
      if (n == 900) begin
        in_chan.valid = 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge clk);
      end

      k     = $urandom_range(0, 99);
      pos_b = POS_W'($urandom());
      if (k < 8) begin
        op    = OP_W'($urandom_range(0, 3));
        pos_a = POS_W'($urandom());
      end else if (k < 18) begin
        op     = OP_W'($urandom_range(0, 2));
        bad_lo = (op == OP_INSERT) ? tracker.held + 2 : tracker.held + 1;
        pos_a  = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(bad_lo, 255));
        if (op == OP_SWAP && $urandom_range(0, 1)) begin
          pos_b = pos_a;
          pos_a = 8'($urandom_range(1, 255));
        end
      end else begin
        if (tracker.held == 0 || $urandom_range(0, 99) < insert_bias) op = OP_INSERT;
        else if ($urandom_range(0, 2) == 0) op = OP_SWAP;
        else op = OP_REMOVE;
        if (op == OP_INSERT) begin
          pos_a = POS_W'($urandom_range(1, tracker.held + 1));
        end else begin
          pos_a = POS_W'($urandom_range(1, tracker.held));
          if (op == OP_SWAP) pos_b = POS_W'($urandom_range(1, tracker.held));
        end
      end
      send_request(op, pos_a, pos_b, pick_value());

      if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
        in_chan.valid = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
  endtask

  initial begin
    tracker                 = new();
    tx_idle_pct             = 0;
    rx_idle_pct             = 0;
    rx_hold_cycles          = 0;
    quiet_tail              = 1'b0;
    requests_sent           = 0;
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.op              = OP_INSERT;
    in_chan.position        = '0;
    in_chan.second_position = '0;
    in_chan.value           = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random(RANDOM_ITEMS);
    in_chan.valid = 1'b0;

    // Wait for the last results, then a little longer to catch strays.
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d request transactions and %0d checked results.",
             requests_sent, tracker.results_checked);
    $display("Outcomes: %0d done, %0d out of range, %0d list full.",
             tracker.done_seen, tracker.range_seen, tracker.full_seen);
    if (tracker.error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
